// ===== hdl/qfis_pkg.sv =====
// shared types and constants for the quadratic stereo fade-in block
`default_nettype none

package qfis_pkg;

    localparam int SAMPLE_W = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_ENABLE  = 2'd2;

    localparam int RAMP_LENGTH_RESET = 48000;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SCALE,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/qfis_in_if.sv =====
// input frame channel: valid/ready with a stereo sample pair
`default_nettype none

interface qfis_in_if;
    logic              valid;
    logic              ready;
    qfis_pkg::t_sample left_sample;
    qfis_pkg::t_sample right_sample;
    logic              block_end;

    modport source (output valid, output left_sample, output right_sample,
                    output block_end, input ready);
    modport sink   (input valid, input left_sample, input right_sample,
                    input block_end, output ready);
endinterface

`default_nettype wire

// ===== hdl/qfis_out_if.sv =====
// output frame channel: valid/ready with scaled samples and status flags
`default_nettype none

interface qfis_out_if;
    logic              valid;
    logic              ready;
    qfis_pkg::t_sample left_out;
    qfis_pkg::t_sample right_out;
    logic              in_ramp;
    logic              effect_done;
    logic              block_end_out;

    modport source (output valid, output left_out, output right_out, output in_ramp,
                    output effect_done, output block_end_out, input ready);
    modport sink   (input valid, input left_out, input right_out, input in_ramp,
                    input effect_done, input block_end_out, output ready);
endinterface

`default_nettype wire

// ===== hdl/qfis_smul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
`default_nettype none

module qfis_smul #(
    parameter int A_W = 16,
    parameter int B_W = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [A_W-1:0]     i_a,
    input  wire logic [B_W-1:0]     i_b,
    output logic                    o_done,
    output logic [A_W+B_W-1:0]      o_prod
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [A_W-1:0]   r_a;
    logic [A_W-1:0]   r_acc;
    logic [B_W-1:0]   r_low;
    logic [A_W:0]     n_sum;

    // acc stays below a, so the sum fits one extra bit
    assign n_sum = {1'b0, r_acc} + (r_low[0] ? {1'b0, r_a} : {(A_W+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(B_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // product bits shift into the multiplier register as its bits are used
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_acc <= '0;
            r_low <= i_b;
        end else if (r_busy) begin
            r_acc <= n_sum[A_W:1];
            r_low <= {n_sum[0], r_low[B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_acc, r_low};

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("multiplier done while still busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("multiplier did not start");

    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_cnt == '0)
        else $error("multiplier count left over when idle");

endmodule

`default_nettype wire

// ===== hdl/qfis_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none

module qfis_div #(
    parameter int N_W = 48,
    parameter int Q_W = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [N_W-1:0]  i_num,
    input  wire logic [N_W-1:0]  i_den,
    output logic                 o_done,
    output logic [Q_W-1:0]       o_quo
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [N_W-1:0]   r_rem;
    logic [N_W-1:0]   r_den;
    logic [Q_W-1:0]   r_quo;
    logic [N_W:0]     n_shift;
    logic [N_W:0]     n_diff;
    logic             n_ge;

    // remainder stays below the divisor, so doubling fits one extra bit
    assign n_shift = {r_rem, 1'b0};
    assign n_diff  = n_shift - {1'b0, r_den};
    assign n_ge    = !n_diff[N_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[N_W-1:0] : n_shift[N_W-1:0];
            r_quo <= {r_quo[Q_W-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// ===== hdl/quadratic_fade_in_stereo.sv =====
// quadratic stereo fade-in: top level with control sequencer and frame datapath
//
// Frames enter on i_frame (valid/ready) and leave on o_frame (valid/ready), one
// result per frame, in order. Registers (ramp length, sustain, end enable) are
// written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must write them only
// while the block is idle, and the block itself does not enforce this.
// A frame inside the ramp computes (2L-n)*n and L*L on bit-serial multipliers,
// divides them in a restoring divider and scales both samples on bit-serial
// multipliers; a handoff step follows each unit and a last step loads the
// output register. A sustain frame only scales, and a pass-through frame goes
// straight to loading the output. One frame is in work at a time; the serial
// units set the rate.
// The result sits in an output register, so once a frame has been finished
// the next one can be taken and worked on while the receiver stalls; the
// block holds in its final step only when that register is still full.
// Reset (synchronous, active low) clears the frame counter and held gain,
// loads the register defaults and empties the output register.
`default_nettype none

module quadratic_fade_in_stereo #(
    parameter int LENGTH_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    qfis_in_if.sink                               i_frame,
    qfis_out_if.source                            o_frame,
    input  wire logic                             i_cfg_we,
    input  wire logic [qfis_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [LENGTH_BITS-1:0]           i_cfg_data
);

    localparam int LB = LENGTH_BITS;
    localparam int GF = GAIN_FRAC_BITS;
    localparam int SW = qfis_pkg::SAMPLE_W;
    localparam int NW = 2 * LB;

    qfis_pkg::t_state r_state, n_state;

    logic [LB-1:0] r_len;
    logic          r_sus;
    logic          r_endb;
    logic [LB-1:0] r_fc;
    logic [GF-1:0] r_gain;

    logic [SW-1:0] r_lraw, r_rraw;
    logic          r_pass, r_inr, r_edone, r_bend;

    logic          r_ovalid;
    logic [SW-1:0] r_oleft, r_oright;
    logic          r_oinr, r_odone, r_obend;

    logic          in_acc;
    logic          ramp;
    logic [LB-1:0] fc_inc, fc_next;
    logic          edone;
    logic          mul_start, div_start, scl_start, out_load;
    logic          mul_done, div_done, scl_done;
    logic          den_done, scl_r_done;
    logic [LB:0]   num_a;
    logic [NW:0]   num_prod;
    logic [NW-1:0] den_prod;
    logic [GF-1:0] div_quo;
    logic [GF-1:0] scl_gain;
    logic [SW-1:0] l_mag, r_mag;
    logic [SW+GF-1:0] l_prod, r_prod;
    logic [SW-1:0] l_hi, r_hi, l_res, r_res;

    function automatic logic [SW-1:0] f_mag(input logic [SW-1:0] s);
        f_mag = s[SW-1] ? (~s + SW'(1)) : s;
    endfunction

    assign in_acc = i_frame.valid && i_frame.ready;
    assign ramp   = r_fc < r_len;
    assign fc_inc = r_fc + LB'(1);

    // counter advances in the ramp and in sustain, saturating at all ones
    always_comb begin
        if (ramp) begin
            fc_next = fc_inc;
        end else if (r_sus && (r_fc != {LB{1'b1}})) begin
            fc_next = fc_inc;
        end else begin
            fc_next = r_fc;
        end
    end

    assign edone = r_endb && (({1'b0, fc_next} + (LB+1)'(1)) >= {1'b0, r_len});
    assign num_a = {r_len, 1'b0} - {1'b0, r_fc};

    // sustain frames start scaling straight from the input port
    assign l_mag    = (r_state == qfis_pkg::ST_IDLE) ? f_mag(i_frame.left_sample)
                                                     : f_mag(r_lraw);
    assign r_mag    = (r_state == qfis_pkg::ST_IDLE) ? f_mag(i_frame.right_sample)
                                                     : f_mag(r_rraw);
    assign scl_gain = (r_state == qfis_pkg::ST_DIV) ? div_quo : r_gain;

    qfis_smul #(.A_W(LB + 1), .B_W(LB)) u_num_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (num_a),
        .i_b     (r_fc),
        .o_done  (mul_done),
        .o_prod  (num_prod)
    );

    qfis_smul #(.A_W(LB), .B_W(LB)) u_den_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_len),
        .i_b     (r_len),
        .o_done  (den_done),
        .o_prod  (den_prod)
    );

    qfis_div #(.N_W(NW), .Q_W(GF)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_prod[NW-1:0]),
        .i_den   (den_prod),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    qfis_smul #(.A_W(SW), .B_W(GF)) u_left_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scl_start),
        .i_a     (l_mag),
        .i_b     (scl_gain),
        .o_done  (scl_done),
        .o_prod  (l_prod)
    );

    qfis_smul #(.A_W(SW), .B_W(GF)) u_right_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scl_start),
        .i_a     (r_mag),
        .i_b     (scl_gain),
        .o_done  (scl_r_done),
        .o_prod  (r_prod)
    );

    // drop the fraction, then restore the sign: truncation toward zero
    assign l_hi  = l_prod[SW+GF-1:GF];
    assign r_hi  = r_prod[SW+GF-1:GF];
    assign l_res = r_pass ? r_lraw : (r_lraw[SW-1] ? (~l_hi + SW'(1)) : l_hi);
    assign r_res = r_pass ? r_rraw : (r_rraw[SW-1] ? (~r_hi + SW'(1)) : r_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qfis_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        div_start = 1'b0;
        scl_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            qfis_pkg::ST_IDLE: begin
                if (i_frame.valid) begin
                    if (ramp) begin
                        mul_start = 1'b1;
                        n_state   = qfis_pkg::ST_MUL;
                    end else if (r_sus) begin
                        scl_start = 1'b1;
                        n_state   = qfis_pkg::ST_SCALE;
                    end else begin
                        n_state = qfis_pkg::ST_DONE;
                    end
                end
            end
            qfis_pkg::ST_MUL: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    n_state   = qfis_pkg::ST_DIV;
                end
            end
            qfis_pkg::ST_DIV: begin
                if (div_done) begin
                    scl_start = 1'b1;
                    n_state   = qfis_pkg::ST_SCALE;
                end
            end
            qfis_pkg::ST_SCALE: begin
                if (scl_done) begin
                    n_state = qfis_pkg::ST_DONE;
                end
            end
            qfis_pkg::ST_DONE: begin
                if (!r_ovalid || o_frame.ready) begin
                    out_load = 1'b1;
                    n_state  = qfis_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = qfis_pkg::ST_IDLE;
            end
        endcase
    end

    // configuration, frame counter and held gain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LB'(qfis_pkg::RAMP_LENGTH_RESET);
            r_sus  <= 1'b1;
            r_endb <= 1'b0;
            r_fc   <= '0;
            r_gain <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    qfis_pkg::CFG_RAMP_LENGTH: r_len  <= i_cfg_data;
                    qfis_pkg::CFG_SUSTAIN:     r_sus  <= i_cfg_data[0];
                    qfis_pkg::CFG_END_ENABLE:  r_endb <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_fc <= fc_next;
            end
            if (div_done) begin
                r_gain <= div_quo;
            end
        end
    end

    // per-transaction capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_lraw  <= i_frame.left_sample;
            r_rraw  <= i_frame.right_sample;
            r_pass  <= !ramp && !r_sus;
            r_inr   <= ramp;
            r_edone <= edone;
            r_bend  <= i_frame.block_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_frame.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_oleft  <= l_res;
            r_oright <= r_res;
            r_oinr   <= r_inr;
            r_odone  <= r_edone;
            r_obend  <= r_bend;
        end
    end

    assign i_frame.ready         = (r_state == qfis_pkg::ST_IDLE);
    assign o_frame.valid         = r_ovalid;
    assign o_frame.left_out      = r_oleft;
    assign o_frame.right_out     = r_oright;
    assign o_frame.in_ramp       = r_oinr;
    assign o_frame.effect_done   = r_odone;
    assign o_frame.block_end_out = r_obend;

    a_fc_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_fc >= $past(r_fc))
        else $error("frame counter went backwards");

    a_gain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(div_done)) |-> $stable(r_gain))
        else $error("gain changed without a division");

    a_mul_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> r_state == qfis_pkg::ST_MUL)
        else $error("multiply finished outside its step");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == qfis_pkg::ST_DIV)
        else $error("division finished outside its step");

    // numerator must fit the divider and both ramp products finish together
    a_mul_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (den_done && !num_prod[NW]))
        else $error("ramp products out of step or too wide");

    a_scl_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scl_done == scl_r_done)
        else $error("scaling lanes out of step");

endmodule

`default_nettype wire

// ===== tb/tb_quadratic_fade_in_stereo.sv =====
// self-checking testbench for the quadratic stereo fade-in block
`default_nettype none

module tb_quadratic_fade_in_stereo;

    import qfis_pkg::*;

    localparam int          LEN_W       = 24;
    localparam int          GAIN_W      = 16;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int          TAIL_CYCLES = 80;
    localparam int          RAND_FRAMES = 1350;

    typedef struct packed {
        t_sample left;
        t_sample right;
        logic    in_ramp;
        logic    done;
        logic    blk_end;
    } t_frame_res;

    typedef enum logic {ROW_REG, ROW_FRAME} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [LEN_W-1:0]     data;
        t_sample              left;
        t_sample              right;
        logic                 blk_end;
        logic                 typed;
        t_frame_res           want;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [LEN_W-1:0]     i_cfg_data;

    qfis_in_if  frame_in ();
    qfis_out_if frame_out ();

    quadratic_fade_in_stereo #(
        .LENGTH_BITS    (LEN_W),
        .GAIN_FRAC_BITS (GAIN_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_frame    (frame_in),
        .o_frame    (frame_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state and register copies
    logic [LEN_W-1:0]  fade_len;
    logic              hold_on;
    logic              done_en;
    logic [LEN_W-1:0]  frame_count;
    logic [GAIN_W-1:0] held_gain;

    t_frame_res  pending_frames[$];
    t_frame_res  oldest;
    int          errors       = 0;
    int          results_seen = 0;
    int unsigned cycle_count  = 0;
    logic        steady       = 1'b0;

    // zero length, ramp start, short ramps that run out, pass-through, longest ramp
    t_row dir_rows [0:23] = '{
        '{ROW_REG,   CFG_RAMP_LENGTH, 24'd0, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
        '{ROW_FRAME, '0, '0, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1,
          '{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b1}},
        '{ROW_REG,   CFG_RAMP_LENGTH, 24'd48000, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
        '{ROW_FRAME, '0, '0, 16'sh8000, 16'sh7FFF, 1'b0, 1'b0, '0},
        '{ROW_FRAME, '0, '0, 16'sd1, -16'sd1, 1'b1, 1'b0, '0},
        '{ROW_REG,   CFG_RAMP_LENGTH, 24'd1, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
        '{ROW_FRAME, '0, '0, 16'sh7FFF, 16'sh8000, 1'b0, 1'b0, '0},
        '{ROW_REG,   CFG_END_ENABLE, 24'd1, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
        '{ROW_FRAME, '0, '0, -16'sd1, 16'sd1, 1'b1, 1'b0, '0},
        '{ROW_REG,   CFG_SUSTAIN, 24'd0, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
        '{ROW_FRAME, '0, '0, 16'sh8000, 16'sh7FFF, 1'b0, 1'b1,
          '{16'sh8000, 16'sh7FFF, 1'b0, 1'b1, 1'b0}},
        '{ROW_FRAME, '0, '0, 16'sd0, -16'sd1, 1'b1, 1'b1,
          '{16'sd0, -16'sd1, 1'b0, 1'b1, 1'b1}},
        '{ROW_REG,   CFG_RAMP_LENGTH, 24'd0, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
        '{ROW_FRAME, '0, '0, 16'sd12345, -16'sd12345, 1'b0, 1'b1,
          '{16'sd12345, -16'sd12345, 1'b0, 1'b1, 1'b0}},
        '{ROW_REG,   CFG_SUSTAIN, 24'd1, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
        '{ROW_FRAME, '0, '0, 16'sh7FFF, 16'sh8000, 1'b1, 1'b0, '0},
        '{ROW_REG,   CFG_RAMP_LENGTH, 24'd8, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
        '{ROW_FRAME, '0, '0, 16'sh7FFF, 16'sh8000, 1'b0, 1'b0, '0},
        '{ROW_FRAME, '0, '0, 16'sh8000, 16'sh7FFF, 1'b1, 1'b0, '0},
        '{ROW_FRAME, '0, '0, 16'sh7FFF, 16'sh8000, 1'b0, 1'b0, '0},
        '{ROW_REG,   CFG_END_ENABLE, 24'd0, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
        '{ROW_REG,   CFG_RAMP_LENGTH, 24'hFFFFFF, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
        '{ROW_FRAME, '0, '0, -16'sd1, 16'sh7FFF, 1'b1, 1'b0, '0},
        '{ROW_FRAME, '0, '0, 16'sh8000, 16'sd1, 1'b0, 1'b0, '0}
    };

    // gain = floor((2L - n) * n * 2^16 / L^2), restoring division
    function automatic logic [GAIN_W-1:0] fade_gain(logic [LEN_W-1:0] step,
                                                     logic [LEN_W-1:0] len);
        logic [63:0]       den;
        logic [63:0]       rem;
        logic [GAIN_W-1:0] q;
        int                i;
        den = 64'(len) * 64'(len);
        rem = (64'(len) * 2 - 64'(step)) * 64'(step);
        q   = '0;
        for (i = 0; i < GAIN_W; i++) begin
            rem = rem << 1;
            if (rem >= den) begin
                rem = rem - den;
                q   = {q[GAIN_W-2:0], 1'b1};
            end else begin
                q   = {q[GAIN_W-2:0], 1'b0};
            end
        end
        return q;
    endfunction

    // sign-magnitude multiply, truncates toward zero
    function automatic t_sample apply_gain(t_sample s, logic [GAIN_W-1:0] g);
        logic [16:0] mag;
        logic [32:0] prod;
        logic [15:0] p;
        mag = {1'b0, s};
        if (s[15]) mag = 17'h10000 - mag;
        prod = mag * g;
        p    = prod[31:16];
        if (s[15]) p = 16'h0 - p;
        return t_sample'(p);
    endfunction

    function automatic t_frame_res fade_frame(t_sample l, t_sample r, logic b);
        t_frame_res res;
        res.left    = l;
        res.right   = r;
        res.in_ramp = 1'b0;
        res.blk_end = b;
        if (frame_count < fade_len) begin
            res.in_ramp = 1'b1;
            held_gain   = fade_gain(frame_count, fade_len);
            res.left    = apply_gain(l, held_gain);
            res.right   = apply_gain(r, held_gain);
            frame_count = frame_count + 1'b1;
        end else if (hold_on) begin
            res.left  = apply_gain(l, held_gain);
            res.right = apply_gain(r, held_gain);
            if (frame_count != '1) frame_count = frame_count + 1'b1;
        end
        res.done = done_en && (({1'b0, frame_count} + 25'd1) >= {1'b0, fade_len});
        return res;
    endfunction

    function automatic t_sample pick_sample();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return t_sample'($urandom_range(2) - 1);
            default: return t_sample'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < 100) $display("mismatch: %s", msg);
        errors++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s got %0d, want %0d",
                                      results_seen, name, got, want));
    endtask

    // one input transaction; the expectation is queued at the accepting edge
    task automatic push_frame(input t_sample l, input t_sample r, input logic b,
                              input logic typed, input t_frame_res want);
        t_frame_res model_res;
        i_cfg_we <= 1'b0;
        while (!steady && $urandom_range(99) < 29) begin
            frame_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        frame_in.valid        <= 1'b1;
        frame_in.left_sample  <= l;
        frame_in.right_sample <= r;
        frame_in.block_end    <= b;
        @(posedge i_clk);
        while (!frame_in.ready) @(posedge i_clk);
        model_res = fade_frame(l, r, b);
        pending_frames.push_back(typed ? want : model_res);
    endtask

    task automatic settle();
        frame_in.valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
    endtask

    // write enable stays high through back-to-back writes, push_frame lowers it
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_RAMP_LENGTH: fade_len = data;
            CFG_SUSTAIN:     hold_on  = data[0];
            CFG_END_ENABLE:  done_en  = data[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && frame_out.valid && frame_out.ready) begin
            if (pending_frames.size() == 0) begin
                report_mismatch($sformatf("result %0d with no frame pending", results_seen));
            end else begin
                oldest = pending_frames.pop_front();
                check_field("left_out", frame_out.left_out, oldest.left);
                check_field("right_out", frame_out.right_out, oldest.right);
                check_field("in_ramp", frame_out.in_ramp, oldest.in_ramp);
                check_field("effect_done", frame_out.effect_done, oldest.done);
                check_field("block_end_out", frame_out.block_end_out, oldest.blk_end);
            end
            results_seen++;
        end
        frame_out.ready <= steady || ($urandom_range(99) >= 29);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_quadratic_fade_in_stereo: done, errors");
            $finish;
        end
    end

    initial begin
        logic [LEN_W-1:0] new_len;
        int               n_frames;
        int               sent;
        fade_len    = LEN_W'(RAMP_LENGTH_RESET);
        hold_on     = 1'b1;
        done_en     = 1'b0;
        frame_count = '0;
        held_gain   = '0;
        sent        = 0;

        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = CFG_RAMP_LENGTH;
        i_cfg_data             = '0;
        frame_in.valid         = 1'b0;
        frame_in.left_sample   = '0;
        frame_in.right_sample  = '0;
        frame_in.block_end     = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_REG) begin
                settle();
                cfg_write(dir_rows[k].idx, dir_rows[k].data);
            end else begin
                push_frame(dir_rows[k].left, dir_rows[k].right, dir_rows[k].blk_end,
                           dir_rows[k].typed, dir_rows[k].want);
            end
        end

        // phases: mostly short ramps starting at the current count so they run out
        while (sent < RAND_FRAMES) begin
            settle();
            case ($urandom_range(11))
                0:       new_len = '0;
                1:       new_len = '1;
                2:       new_len = LEN_W'($urandom_range(frame_count));
                3:       new_len = LEN_W'($urandom());
                default: new_len = frame_count + LEN_W'($urandom_range(48, 1));
            endcase
            cfg_write(CFG_RAMP_LENGTH, new_len);
            if ($urandom_range(1))
                cfg_write(CFG_SUSTAIN, LEN_W'($urandom_range(99) < 75));
            if ($urandom_range(1))
                cfg_write(CFG_END_ENABLE, LEN_W'($urandom_range(1)));
            n_frames = $urandom_range(60, 4);
            repeat (n_frames) begin
                steady <= (sent >= 500 && sent < 700);
                push_frame(pick_sample(), pick_sample(), 1'($urandom_range(1)), 1'b0, '0);
                sent++;
            end
        end

        steady <= 1'b0;
        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_quadratic_fade_in_stereo: done, clean");
        end else begin
            $display("tb_quadratic_fade_in_stereo: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
